// File: rtl/eled_pkg.sv
// shared types and constants for the echo line editor
package eled_pkg;

  localparam int CHAR_W = 8;
  localparam int CFG_W  = 7;
  // a kept line never exceeds 63 characters
  localparam int LEN_W  = 6;
  localparam int LEN_MAX = 63;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CFG_W-1:0]  MAX_LINE_RESET = 7'd64;

  typedef enum logic [1:0] {
    SEL_ECHO_CHAR,
    SEL_ECHO_BS,
    SEL_LINE_CHAR,
    SEL_TERM
  } out_sel_t;

  typedef struct packed {
    logic     load_out;
    out_sel_t out_sel;
    logic     wr_en;
    logic     rd_en;
    logic     len_inc;
    logic     len_dec;
    logic     len_clr;
    logic     idx_clr;
    logic     idx_inc;
  } cmd_t;

  typedef struct packed {
    logic is_return;
    logic is_backspace;
    logic len_zero;
    logic room;
    logic idx_last;
    logic slot_free;
  } status_t;

endpackage

// File: rtl/eled_ram.sv
// generic single write port, single read port ram with registered read
module eled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/eled_ctrl.sv
// controller state machine for the echo line editor
module eled_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  eled_pkg::status_t status,
  output eled_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_TERM
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_stall = !((state == ST_IDLE) && status.slot_free);
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    cmd.out_sel = eled_pkg::SEL_ECHO_CHAR;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (status.is_return) begin
            if (status.len_zero) begin
              cmd.load_out = 1'b1;
              cmd.out_sel  = eled_pkg::SEL_TERM;
              cmd.len_clr  = 1'b1;
            end else begin
              cmd.idx_clr = 1'b1;
              state_next  = ST_READ;
            end
          end else if (status.is_backspace) begin
            if (!status.len_zero) begin
              cmd.load_out = 1'b1;
              cmd.out_sel  = eled_pkg::SEL_ECHO_BS;
              cmd.len_dec  = 1'b1;
            end
          end else if (status.room) begin
            cmd.load_out = 1'b1;
            cmd.out_sel  = eled_pkg::SEL_ECHO_CHAR;
            cmd.wr_en    = 1'b1;
            cmd.len_inc  = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = eled_pkg::SEL_LINE_CHAR;
          cmd.idx_inc  = 1'b1;
          state_next   = status.idx_last ? ST_TERM : ST_READ;
        end
      end
      ST_TERM: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = eled_pkg::SEL_TERM;
          cmd.len_clr  = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/eled_dp.sv
// datapath: line store, length, read index, capacity register and output register
module eled_dp #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [eled_pkg::CHAR_W-1:0]      rx_char,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eled_pkg::CFG_W-1:0]       max_line,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [eled_pkg::CHAR_W-1:0]      out_byte,
  output logic                             out_last,
  input  eled_pkg::cmd_t                   cmd,
  output eled_pkg::status_t                status
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int LW = eled_pkg::LEN_W;
  localparam int CW = eled_pkg::CFG_W;
  localparam int CAP_LIMIT =
    (LINE_DEPTH - 1 < eled_pkg::LEN_MAX) ? LINE_DEPTH - 1 : eled_pkg::LEN_MAX;

  logic [CW-1:0]                   line_cap_cfg;
  logic [LW-1:0]                   len;
  logic [LW-1:0]                   idx;
  logic [CW-1:0]                   cap;
  logic [CW-1:0]                   cap_raw;
  logic [AW+LW-1:0]                wr_ext;
  logic [AW+LW-1:0]                rd_ext;
  logic [AW-1:0]                   wr_addr;
  logic [AW-1:0]                   rd_addr;
  logic [eled_pkg::CHAR_W-1:0]     rd_data;
  logic                            out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cap_cfg <= eled_pkg::MAX_LINE_RESET;
    end else if (cfg_valid) begin
      line_cap_cfg <= max_line;
    end
  end

  // capacity: min(max_line - 1, depth - 1, 63)
  always_comb begin
    cap_raw = (line_cap_cfg == '0) ? '0 : line_cap_cfg - CW'(1);
    cap     = (cap_raw > CW'(CAP_LIMIT)) ? CW'(CAP_LIMIT) : cap_raw;
  end

  assign wr_ext  = {{AW{1'b0}}, len};
  assign rd_ext  = {{AW{1'b0}}, idx};
  assign wr_addr = wr_ext[AW-1:0];
  assign rd_addr = rd_ext[AW-1:0];

  eled_ram #(
    .WIDTH (eled_pkg::CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_char),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.len_clr) begin
      len <= '0;
    end else if (cmd.len_inc) begin
      len <= len + LW'(1);
    end else if (cmd.len_dec) begin
      len <= len - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + LW'(1);
    end
  end

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_sel)
        eled_pkg::SEL_ECHO_CHAR: begin
          out_kind <= 1'b0;
          out_byte <= rx_char;
          out_last <= 1'b0;
        end
        eled_pkg::SEL_ECHO_BS: begin
          out_kind <= 1'b0;
          out_byte <= eled_pkg::CH_BACKSPACE;
          out_last <= 1'b0;
        end
        eled_pkg::SEL_LINE_CHAR: begin
          out_kind <= 1'b1;
          out_byte <= rd_data;
          out_last <= 1'b0;
        end
        default: begin
          out_kind <= 1'b1;
          out_byte <= '0;
          out_last <= 1'b1;
        end
      endcase
    end
  end

  assign status.is_return    = (rx_char == eled_pkg::CH_RETURN);
  assign status.is_backspace = (rx_char == eled_pkg::CH_BACKSPACE);
  assign status.len_zero     = (len == '0);
  assign status.room         = ({1'b0, len} < cap);
  assign status.idx_last     = (({1'b0, idx} + (LW+1)'(1)) == {1'b0, len});
  assign status.slot_free    = !out_valid || !out_stall;

endmodule

// File: rtl/echo_line_editor_unit.sv
// top level of the echo line editor
// Terminal line input: each received character that fits is echoed and kept in
// the line store, a backspace on a non-empty line removes the last kept
// character and echoes a backspace, and a carriage return sends the kept line
// followed by a zero terminator marked last. After an ordinary character or
// backspace a new request is taken in the next cycle while the output register
// is free or being drained. A carriage return on a non-empty line stalls input
// until the line and terminator are sent: the line store has one registered
// read port, so each stored character passes through a read state and a load
// state. A carriage return on an empty line sends the terminator directly. The
// store needs no clearing after reset; the capacity register may be written at
// any time the block is idle and is always ready.
module echo_line_editor_unit #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [eled_pkg::CHAR_W-1:0] rx_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [eled_pkg::CHAR_W-1:0] out_byte,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [eled_pkg::CFG_W-1:0]  max_line
);

  eled_pkg::cmd_t    cmd;
  eled_pkg::status_t status;

  eled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  eled_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_char   (rx_char),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .max_line  (max_line),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: tb/tb_echo_line_editor_unit.sv
// testbench for echo_line_editor_unit: directed table then random lines checked against a predictor
`timescale 1ns / 100ps

module tb_echo_line_editor_unit;

  localparam int LINE_DEPTH    = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_ITEMS   = 40;
  localparam int N_PHASES      = 8;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_ONE_RESULT
  } row_kind_t;

  typedef struct packed {
    logic                        kind;
    logic [eled_pkg::CHAR_W-1:0] data;
    logic                        last;
  } line_result_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [eled_pkg::CHAR_W-1:0] val;
    line_result_t                res;
  } stim_row_t;

  localparam line_result_t NO_RES = '0;

  localparam stim_row_t DIRECTED_ROWS [30] = '{
    '{ROW_ONE_RESULT, eled_pkg::CH_RETURN,    '{1'b1, 8'h00, 1'b1}},
    '{ROW_NO_RESULT,  eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_ONE_RESULT, 8'h00,                  '{1'b0, 8'h00, 1'b0}},
    '{ROW_ONE_RESULT, 8'hFF,                  '{1'b0, 8'hFF, 1'b0}},
    '{ROW_PREDICT,    8'h41,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_PREDICT,    8'h42,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_RETURN,    NO_RES},
    '{ROW_CFG,        8'd3,                   NO_RES},
    '{ROW_PREDICT,    8'h61,                  NO_RES},
    '{ROW_PREDICT,    8'h62,                  NO_RES},
    '{ROW_PREDICT,    8'h63,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_PREDICT,    8'h64,                  NO_RES},
    '{ROW_PREDICT,    8'h65,                  NO_RES},
    '{ROW_CFG,        8'd2,                   NO_RES},
    '{ROW_PREDICT,    8'h66,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_PREDICT,    8'h67,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_PREDICT,    8'h68,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_RETURN,    NO_RES},
    '{ROW_CFG,        8'd1,                   NO_RES},
    '{ROW_NO_RESULT,  8'h69,                  NO_RES},
    '{ROW_ONE_RESULT, eled_pkg::CH_RETURN,    '{1'b1, 8'h00, 1'b1}},
    '{ROW_NO_RESULT,  eled_pkg::CH_BACKSPACE, NO_RES},
    '{ROW_CFG,        8'd64,                  NO_RES},
    '{ROW_PREDICT,    8'h80,                  NO_RES},
    '{ROW_PREDICT,    8'h7F,                  NO_RES},
    '{ROW_PREDICT,    eled_pkg::CH_RETURN,    NO_RES}
  };

  localparam logic [eled_pkg::CFG_W-1:0] PHASE_MAX_LINE [N_PHASES] = '{
    7'd64, 7'd1, 7'd33, 7'd2, 7'd63, 7'd17, 7'd64, 7'd64
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [eled_pkg::CHAR_W-1:0] rx_char = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_kind;
  logic [eled_pkg::CHAR_W-1:0] out_byte;
  logic                        out_last;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [eled_pkg::CFG_W-1:0]  max_line = eled_pkg::MAX_LINE_RESET;

  // predictor state
  logic [eled_pkg::CHAR_W-1:0] line_buf [LINE_DEPTH];
  int                          line_len = 0;
  logic [eled_pkg::CFG_W-1:0]  max_line_cfg = eled_pkg::MAX_LINE_RESET;
  line_result_t                caused [$];
  line_result_t                pending_out [$];
  line_result_t                want;

  idle_mode_t idle_mode = IDLE_NONE;
  int mismatches   = 0;
  int chars_sent   = 0;
  int results_seen = 0;
  int lines_seen   = 0;
  int cfg_writes   = 0;
  int cycle_count  = 0;

  echo_line_editor_unit #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_char   (rx_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .max_line  (max_line)
  );

  always #6 clk = ~clk;

  function automatic int line_capacity();
    int cap;
    cap = (max_line_cfg == 0) ? 0 : int'(max_line_cfg) - 1;
    if (cap > LINE_DEPTH - 1) cap = LINE_DEPTH - 1;
    if (cap > eled_pkg::LEN_MAX) cap = eled_pkg::LEN_MAX;
    return cap;
  endfunction

  function automatic void edit_line(input logic [eled_pkg::CHAR_W-1:0] ch);
    caused.delete();
    if (ch == eled_pkg::CH_RETURN) begin
      for (int i = 0; i < line_len; i++) begin
        caused.push_back(line_result_t'{1'b1, line_buf[i], 1'b0});
      end
      caused.push_back(line_result_t'{1'b1, 8'h00, 1'b1});
      line_len = 0;
    end else if (ch == eled_pkg::CH_BACKSPACE) begin
      if (line_len != 0) begin
        line_len--;
        caused.push_back(line_result_t'{1'b0, eled_pkg::CH_BACKSPACE, 1'b0});
      end
    end else if (line_len < line_capacity()) begin
      line_buf[line_len] = ch;
      line_len++;
      caused.push_back(line_result_t'{1'b0, ch, 1'b0});
    end
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 88;
      IDLE_BOTH:   return $urandom_range(0, 99) < 18;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic [eled_pkg::CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 9) return eled_pkg::CH_RETURN;
    if (r < 20) return eled_pkg::CH_BACKSPACE;
    if (r < 35) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // starts and ends at a falling edge
  task automatic send_char(input logic [eled_pkg::CHAR_W-1:0] ch, input row_kind_t kind,
                           input line_result_t typed);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_char  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    edit_line(ch);
    case (kind)
      ROW_NO_RESULT:  ;
      ROW_ONE_RESULT: pending_out.push_back(typed);
      default:        foreach (caused[i]) pending_out.push_back(caused[i]);
    endcase
    @(negedge clk);
  endtask

  task automatic write_max_line(input logic [eled_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    max_line  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_line_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= $urandom_range(0, 99) < 88;
        IDLE_BOTH:     out_stall <= $urandom_range(0, 99) < 18;
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h last %0d", out_kind, out_byte, out_last);
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          mismatches++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
        if (want.last) lines_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_out.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int fill;
    int n;
    logic [eled_pkg::CFG_W-1:0] setting;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        write_max_line(DIRECTED_ROWS[i].val[eled_pkg::CFG_W-1:0]);
      end else begin
        send_char(DIRECTED_ROWS[i].val, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      setting = (p == N_PHASES - 1) ? 7'($urandom_range(1, 64)) : PHASE_MAX_LINE[p];
      write_max_line(setting);
      idle_mode = idle_mode_t'(p % 4);
      n = 0;
      // fill a line past its capacity, then close it
      if (p == 0 || line_capacity() < 40) begin
        fill = line_capacity() + 2;
        repeat (fill) begin
          send_char(8'($urandom_range(32, 126)), ROW_PREDICT, NO_RES);
          n++;
        end
        send_char(eled_pkg::CH_RETURN, ROW_PREDICT, NO_RES);
        n++;
      end
      while (n < PHASE_ITEMS) begin
        send_char(pick_char(), ROW_PREDICT, NO_RES);
        n++;
      end
    end
    in_valid <= 1'b0;

    while (pending_out.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d characters under %0d capacity settings, all idle mixes",
             chars_sent, cfg_writes);
    $display("checked %0d results including %0d completed lines", results_seen, lines_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
